/* sv/bldel_pkg.sv */
// Package for the bounded list with positional delete.
// Holds the action codes, the classified command word, status codes and FSM states.
// No dependencies.
package bldel_pkg;

	localparam int VAL_W = 32;
	localparam int IDX_W = 4;
	localparam int POS_W = 4;
	localparam int ACT_W = 2;
	localparam int QDEPTH = 2;

	localparam logic [ACT_W-1:0] ACT_CODE_FRONT  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CODE_BACK   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CODE_DELETE = 2'd2;

	typedef enum logic [1:0] {
		OP_FRONT,
		OP_BACK,
		OP_DELETE,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} st_t;

	typedef enum logic {
		BK_IDLE,
		BK_DUMP
	} bk_state_t;

	typedef struct packed {
		op_t                     op;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} cmd_t;

endpackage

/* sv/bldel_front.sv */
// Front end of the list block: accepts input words and classifies the action.
// Depends on bldel_pkg.
module bldel_front
	import bldel_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [ACT_W-1:0]        action,
	input  logic signed [VAL_W-1:0] item_value,
	input  logic [POS_W-1:0]        position,
	output logic                    cmd_valid,
	input  logic                    cmd_stall,
	output cmd_t                    cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_class;
	logic accept;

	assign in_stall = valid_s1 && cmd_stall;
	assign accept = in_valid && !in_stall;

	always_comb begin
		cmd_class.value = item_value;
		cmd_class.position = position;
		unique case (action)
			ACT_CODE_FRONT:  cmd_class.op = OP_FRONT;
			ACT_CODE_BACK:   cmd_class.op = OP_BACK;
			ACT_CODE_DELETE: cmd_class.op = OP_DELETE;
			default:         cmd_class.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!cmd_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_class;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd = cmd_s1;

endmodule

/* sv/bldel_queue.sv */
// Short command queue between the front end and the list engine.
// Depends on bldel_pkg.
module bldel_queue
	import bldel_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t out_cmd
);

	localparam int PW = $clog2(QDEPTH);
	localparam int FW = $clog2(QDEPTH + 1);

	cmd_t           mem_q [QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [FW-1:0]  fill_q;
	logic           push;
	logic           pop;

	assign in_stall = (fill_q == FW'(QDEPTH));
	assign out_valid = (fill_q != '0);
	assign push = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;
	assign out_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

/* sv/bldel_back.sv */
// List engine: carries out one command on the element registers, then dumps the list
// by rotating it through cell zero into the output register. Depends on bldel_pkg.
module bldel_back
	import bldel_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_stall,
	input  cmd_t                    cmd,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] elem_value,
	output logic [IDX_W-1:0]        elem_index,
	output logic                    last_elem,
	output logic                    list_empty,
	output logic [1:0]              status
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

	bk_state_t state_q;
	bk_state_t state_d;

	logic signed [VAL_W-1:0] cells_q [DEPTH];
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           count_d;
	logic [AW-1:0]           idx_q;
	st_t                     status_q;
	st_t                     status_d;

	logic signed [VAL_W-1:0] out_value_q;
	logic [IDX_W-1:0]        out_index_q;
	logic                    out_last_q;
	logic                    out_empty_q;
	logic [1:0]              out_status_q;
	logic                    out_valid_q;

	logic                    exec;
	logic                    dump_load;
	logic                    exec_front;
	logic                    exec_back;
	logic                    exec_del;
	logic                    rotate;
	logic                    is_full;
	logic                    dump_last;
	logic                    list_nil;
	logic [CMP_W-1:0]        pos_x;
	logic [CMP_W-1:0]        cnt_x;
	logic [AW+IDX_W-1:0]     idx_ext;

	assign is_full = (count_q == CW'(DEPTH));
	assign pos_x = CMP_W'(cmd.position);
	assign cnt_x = CMP_W'(count_q);
	assign list_nil = (count_q == '0);
	assign dump_last = list_nil || ((CW'(idx_q) + 1'b1) == count_q);
	assign idx_ext = (AW + IDX_W)'(idx_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					state_d = BK_DUMP;
				end
			end
			BK_DUMP: begin
				if (dump_load && dump_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_stall = 1'b1;
		exec = 1'b0;
		dump_load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				cmd_stall = 1'b0;
				exec = cmd_valid;
			end
			BK_DUMP: begin
				dump_load = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	always_comb begin
		exec_front = 1'b0;
		exec_back = 1'b0;
		exec_del = 1'b0;
		status_d = ST_DONE;
		count_d = count_q;
		if (exec) begin
			unique case (cmd.op) inside
				OP_FRONT, OP_BACK: begin
					if (is_full) begin
						status_d = ST_FULL;
					end else begin
						exec_front = (cmd.op == OP_FRONT);
						exec_back = (cmd.op == OP_BACK);
						count_d = count_q + 1'b1;
					end
				end
				OP_DELETE: begin
					if (pos_x >= cnt_x) begin
						status_d = ST_RANGE;
					end else begin
						exec_del = 1'b1;
						count_d = count_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign rotate = dump_load && !list_nil;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [VAL_W-1:0] dn_val;
		logic signed [VAL_W-1:0] up_val;
		logic signed [VAL_W-1:0] nxt_val;

		if (g == 0) begin : g_first
			assign dn_val = cmd.value;
		end else begin : g_rest
			assign dn_val = cells_q[g-1];
		end

		if (g + 1 < DEPTH) begin : g_up
			assign up_val = cells_q[g+1];
		end else begin : g_top
			assign up_val = cells_q[g];
		end

		always_comb begin
			nxt_val = cells_q[g];
			if (exec_front) begin
				nxt_val = dn_val;
			end else if (exec_back && (count_q == CW'(g))) begin
				nxt_val = cmd.value;
			end else if (exec_del && (CMP_W'(g) >= pos_x)) begin
				nxt_val = up_val;
			end else if (rotate) begin
				if (count_q == CW'(g + 1)) begin
					nxt_val = cells_q[0];
				end else if (CW'(g + 1) < count_q) begin
					nxt_val = up_val;
				end
			end
		end

		always_ff @(posedge clk) begin
			cells_q[g] <= nxt_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			count_q <= '0;
			idx_q <= '0;
			status_q <= ST_DONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (exec) begin
				status_q <= status_d;
				idx_q <= '0;
			end else if (dump_load) begin
				idx_q <= dump_last ? '0 : idx_q + 1'b1;
			end
			if (dump_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dump_load) begin
			out_value_q <= list_nil ? '0 : cells_q[0];
			out_index_q <= list_nil ? '0 : idx_ext[IDX_W-1:0];
			out_last_q <= dump_last;
			out_empty_q <= list_nil;
			out_status_q <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign elem_value = out_value_q;
	assign elem_index = out_index_q;
	assign last_elem = out_last_q;
	assign list_empty = out_empty_q;
	assign status = out_status_q;

endmodule

/* sv/bounded_list_with_positional_delete.sv */
// Top level of the bounded list with insert at front, append at back and delete at position.
// Depends on bldel_pkg, bldel_front, bldel_queue and bldel_back.
//
// Each accepted word performs one action on a list of up to DEPTH signed values and is
// answered by a dump of the whole list, one word per element from front to back, with the
// final word marked; an empty list answers with a single word marked empty. The list engine
// carries out the action in its idle state and then, in its dump state, loads one word per
// cycle into the single output register while the output is not stalled. The front end
// and its two-entry queue take up to three further words while a dump is under way; a
// stalled output holds the engine, and the input side stalls once those words are held.
module bounded_list_with_positional_delete
	import bldel_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [ACT_W-1:0]        action,
	input  logic signed [VAL_W-1:0] item_value,
	input  logic [POS_W-1:0]        position,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] elem_value,
	output logic [IDX_W-1:0]        elem_index,
	output logic                    last_elem,
	output logic                    list_empty,
	output logic [1:0]              status
);

	logic fq_valid;
	logic fq_stall;
	cmd_t fq_cmd;
	logic qb_valid;
	logic qb_stall;
	cmd_t qb_cmd;

	bldel_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.item_value (item_value),
		.position   (position),
		.cmd_valid  (fq_valid),
		.cmd_stall  (fq_stall),
		.cmd        (fq_cmd)
	);

	bldel_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_stall  (fq_stall),
		.in_cmd    (fq_cmd),
		.out_valid (qb_valid),
		.out_stall (qb_stall),
		.out_cmd   (qb_cmd)
	);

	bldel_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (qb_valid),
		.cmd_stall  (qb_stall),
		.cmd        (qb_cmd),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.elem_value (elem_value),
		.elem_index (elem_index),
		.last_elem  (last_elem),
		.list_empty (list_empty),
		.status     (status)
	);

endmodule

/* sv/bldel_checker.sv */
// Port-level checker for the bounded list, with its bind to the top level.
// Depends on bldel_pkg.
module bldel_checker
	import bldel_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [VAL_W-1:0] elem_value,
	input logic [IDX_W-1:0]        elem_index,
	input logic                    last_elem,
	input logic                    list_empty,
	input logic [1:0]              status
);

	logic [IDX_W-1:0] exp_index_q;
	logic [1:0]       dump_status_q;
	logic             in_dump_q;
	logic             out_take;

	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_index_q <= '0;
			dump_status_q <= ST_DONE;
			in_dump_q <= 1'b0;
		end else if (out_take) begin
			exp_index_q <= last_elem ? '0 : elem_index + 1'b1;
			dump_status_q <= status;
			in_dump_q <= !last_elem;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Output word withdrawn while stalled.");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(elem_value) && $stable(elem_index)
			&& $stable(last_elem) && $stable(list_empty) && $stable(status))
		else $error("Output word changed while stalled.");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && list_empty |-> last_elem && elem_index == '0 && elem_value == '0
			&& !in_dump_q)
		else $error("Empty-list word is malformed.");

	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> elem_index == exp_index_q)
		else $error("Element index out of sequence.");

	a_status_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_dump_q |-> status == dump_status_q && !list_empty)
		else $error("Status changed within one dump.");

endmodule

bind bounded_list_with_positional_delete bldel_checker u_checker (.*);

/* dv/bounded_list_with_positional_delete_test.sv */
// Self-checking testbench for bounded_list_with_positional_delete.
// A small class mirrors the list and holds the awaited dump words. Plain tasks drive the block.
// Depends on bldel_pkg and the block's RTL.
module bounded_list_with_positional_delete_test;
	import bldel_pkg::*;

	localparam int DEPTH = 16;
	localparam int RANDOM_WORDS = 126;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [ACT_W-1:0] ACT_CODE_SPARE = 2'd3;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [IDX_W-1:0]        index;
		logic                    last;
		logic                    empty;
		st_t                     outcome;
	} dump_word_t;

	class list_mirror;
		logic signed [VAL_W-1:0] cells[DEPTH];
		int unsigned count;
		dump_word_t awaited[$];
		int unsigned mismatches;

		function new();
			count = 0;
			mismatches = 0;
		endfunction

		function void note_action(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] val,
				logic [POS_W-1:0] pos);
			st_t outcome;
			dump_word_t w;
			int i;
			outcome = ST_DONE;
			case (act)
				ACT_CODE_FRONT: begin
					if (count >= DEPTH) begin
						outcome = ST_FULL;
					end else begin
						for (i = count; i > 0; i--)
							cells[i] = cells[i-1];
						cells[0] = val;
						count++;
					end
				end
				ACT_CODE_BACK: begin
					if (count >= DEPTH) begin
						outcome = ST_FULL;
					end else begin
						cells[count] = val;
						count++;
					end
				end
				ACT_CODE_DELETE: begin
					if (pos >= count) begin
						outcome = ST_RANGE;
					end else begin
						for (i = pos; i + 1 < count; i++)
							cells[i] = cells[i+1];
						count--;
					end
				end
				default: begin
				end
			endcase
			if (count == 0) begin
				w.value = '0;
				w.index = '0;
				w.last = 1'b1;
				w.empty = 1'b1;
				w.outcome = outcome;
				awaited.push_back(w);
			end else begin
				for (i = 0; i < count; i++) begin
					w.value = cells[i];
					w.index = i[IDX_W-1:0];
					w.last = (i + 1 == count);
					w.empty = 1'b0;
					w.outcome = outcome;
					awaited.push_back(w);
				end
			end
		endfunction

		function void check_word(logic signed [VAL_W-1:0] value, logic [IDX_W-1:0] index,
				logic last, logic empty, logic [1:0] stat);
			dump_word_t w;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display(
						"Unexpected dump word: value %0d index %0d last %0b empty %0b status %0d",
						value, index, last, empty, stat);
			end else begin
				w = awaited.pop_front();
				if (w.value !== value || w.index !== index || w.last !== last ||
						w.empty !== empty || w.outcome !== stat) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("Dump word mismatch: expected value %0d index %0d last %0b ",
							w.value, w.index, w.last);
						$write("empty %0b status %0d, got value %0d index %0d ",
							w.empty, w.outcome, value, index);
						$display("last %0b empty %0b status %0d", last, empty, stat);
					end
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [ACT_W-1:0] action;
	logic signed [VAL_W-1:0] item_value;
	logic [POS_W-1:0] position;
	logic out_valid;
	logic out_stall;
	logic signed [VAL_W-1:0] elem_value;
	logic [IDX_W-1:0] elem_index;
	logic last_elem;
	logic list_empty;
	logic [1:0] status;

	list_mirror mirror = new();
	int words_sent = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit hold_rx = 1'b0;

	bounded_list_with_positional_delete #(.DEPTH(DEPTH)) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.item_value (item_value),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.elem_value (elem_value),
		.elem_index (elem_index),
		.last_elem  (last_elem),
		.list_empty (list_empty),
		.status     (status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] val,
			logic [POS_W-1:0] pos);
		while (!calm && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		item_value <= val;
		position <= pos;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		mirror.note_action(act, val, pos);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_words();
		logic [ACT_W-1:0] act;
		logic signed [VAL_W-1:0] val;
		logic [POS_W-1:0] pos;
		bit grow;
		int n;
		int r;
		grow = 1'b0;
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 30 == 0)
				grow = !grow;
			calm = (n >= 90 && n < 125);
			r = $urandom_range(99);
			if (r < 3)
				act = ACT_CODE_SPARE;
			else if (r < (grow ? 78 : 25))
				act = $urandom_range(1) ? ACT_CODE_BACK : ACT_CODE_FRONT;
			else
				act = ACT_CODE_DELETE;
			case ($urandom_range(9))
				0: val = 32'sh8000_0000;
				1: val = 32'sh7fff_ffff;
				default: val = $urandom;
			endcase
			if (mirror.count > 0 && $urandom_range(9) < 8)
				pos = $urandom_range(mirror.count - 1);
			else
				pos = $urandom_range(DEPTH - 1);
			send_word(act, val, pos);
		end
		calm = 1'b0;
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_CODE_FRONT;
		item_value = '0;
		position = '0;
		out_stall = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty list: a delete is out of range and the spare code does nothing.
		send_word(ACT_CODE_DELETE, 32'sd0, 4'd0);
		send_word(ACT_CODE_SPARE, -32'sd1, 4'd15);
		for (i = 0; i < DEPTH; i++) begin
			case (i)
				0: send_word(ACT_CODE_FRONT, 32'sh7fff_ffff, 4'd15);
				1: send_word(ACT_CODE_BACK, 32'sh8000_0000, 4'd0);
				2: send_word(ACT_CODE_FRONT, 32'sd0, 4'd0);
				3: send_word(ACT_CODE_BACK, -32'sd1, 4'd15);
				default: send_word(i % 2 ? ACT_CODE_BACK : ACT_CODE_FRONT,
					32'sh1357_9bdf * i, 4'd0);
			endcase
		end
		// A full list drops inserts at either end.
		send_word(ACT_CODE_FRONT, 32'sh1234_5678, 4'd0);
		send_word(ACT_CODE_BACK, 32'sh0bad_cafe, 4'd0);
		send_word(ACT_CODE_DELETE, 32'sd0, 4'd15);
		send_word(ACT_CODE_DELETE, 32'sd0, 4'd0);
		send_word(ACT_CODE_DELETE, 32'sd0, 4'd7);
		send_word(ACT_CODE_DELETE, 32'sd0, 4'd13);

		send_random_words();
		in_valid <= 1'b0;

		while (mirror.awaited.size() != 0)
			@(posedge clk);
		repeat (3 * DEPTH) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				mirror.check_word(elem_value, elem_index, last_elem, list_empty, status);
			@(negedge clk);
			out_stall <= hold_rx || (!calm && $urandom_range(99) < 11);
		end
	end

	// The receiver holds off long enough for the block to fill up and stall its input.
	initial begin
		wait (words_sent >= 60);
		@(posedge clk);
		hold_rx = 1'b1;
		repeat (150) @(posedge clk);
		hold_rx = 1'b0;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

endmodule
